// ===== hw/rtl/bpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared constants and types of the bilinear property table lookup block.
// ----------------------------------------------------------------------------
package bpt_pkg;

    // Default grid bounds of the table storage.
    localparam int BPT_MAX_TEMP_POINTS  = 128;
    localparam int BPT_MAX_PRESS_POINTS = 128;

    // Number of property tables.
    localparam int BPT_NUM_TABLES = 6;

    // Width of a point count; holds any count in the parameter range.
    localparam int CNT_W = 12;

    // Grid positions are Q.16; signed position word width.
    localparam int POS_W = 60;

    // Width of one looked-up value, with room for the difference of two.
    localparam int VAL_W = 34;

    // Configuration register indexes.
    localparam logic [2:0] REG_MIN_TEMP   = 3'd0;
    localparam logic [2:0] REG_INV_TEMP   = 3'd1;
    localparam logic [2:0] REG_TEMP_PTS   = 3'd2;
    localparam logic [2:0] REG_MIN_PRESS  = 3'd3;
    localparam logic [2:0] REG_INV_PRESS  = 3'd4;
    localparam logic [2:0] REG_PRESS_PTS  = 3'd5;
    localparam logic [2:0] REG_INTERP     = 3'd6;

    // Table codes.
    localparam logic [2:0] TBL_DENSITY  = 3'd0;
    localparam logic [2:0] TBL_VP       = 3'd3;
    localparam logic [2:0] TBL_VS       = 3'd4;
    localparam logic [2:0] TBL_ENTHALPY = 3'd5;

    // Quantity codes.
    localparam logic [3:0] Q_ENTHALPY = 4'd5;
    localparam logic [3:0] Q_DHDT     = 4'd6;
    localparam logic [3:0] Q_DHDP     = 4'd7;
    localparam logic [3:0] Q_DRHODP   = 4'd8;

    // Request type codes.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // One request as it travels down the pipeline.
    typedef struct packed {
        logic              lookup;
        logic [2:0]        table_sel;
        logic [6:0]        row;
        logic [6:0]        col;
        logic [31:0]       entry;
        logic [3:0]        quantity;
    } req_t;

    // What the result stages need to know about an item.
    typedef struct packed {
        logic       lookup;
        logic [3:0] quantity;
        logic       temp_below;
        logic       temp_above;
        logic       press_below;
        logic       press_above;
    } item_t;

endpackage

// ===== hw/rtl/bilinear_property_table_lookup.sv =====
// ----------------------------------------------------------------------------
// bilinear_property_table_lookup
// Six property tables on a temperature-by-pressure grid with bilinear lookup.
// ----------------------------------------------------------------------------
// Usage. An item is a command: drive the fields and raise start; the transfer
// happens at a rising edge where start is high and busy is low. A write item
// loads one table entry; a lookup item returns a table value, bilinear or
// floor-index, or a forward difference for dH/dT, dH/dp or drho/dp.
// Every item gives exactly one result, shown for one cycle with done high.
// The receiver cannot stall; results must be taken when done is high.
// Busy is registered from each accepted item, and no item is
// taken while it is high, because every lookup reads the four banked table
// memories twice, once for the base point and once for the next grid step.
// Writes take the same path as lookups so results stay in order.
// Configuration goes through the APB-style port; the user must write it only
// while the block is idle, which the block itself does not enforce. pready is
// always high. Reset clears the pipeline and sets the registers to their
// defaults; table contents are undefined until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
module bilinear_property_table_lookup
    import bpt_pkg::*;
#(
    parameter int MAX_TEMP_POINTS  = BPT_MAX_TEMP_POINTS,
    parameter int MAX_PRESS_POINTS = BPT_MAX_PRESS_POINTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [2:0]         table_select,
    input  logic [6:0]         row_index,
    input  logic [6:0]         col_index,
    input  logic signed [31:0] entry_data,
    input  logic [19:0]        temperature,
    input  logic [39:0]        pressure,
    input  logic [3:0]         quantity,
    output logic               done,
    output logic signed [47:0] result_value,
    output logic               temp_below,
    output logic               temp_above,
    output logic               press_below,
    output logic               press_above,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    // Grid index widths and the geometry of the four parity banks.
    localparam int ROW_W      = $clog2(MAX_TEMP_POINTS);
    localparam int COL_W      = $clog2(MAX_PRESS_POINTS);
    localparam int HALF_T     = (MAX_TEMP_POINTS + 1) / 2;
    localparam int HALF_P     = (MAX_PRESS_POINTS + 1) / 2;
    localparam int TSTRIDE    = HALF_T * HALF_P;
    localparam int BANK_DEPTH = BPT_NUM_TABLES * TSTRIDE;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam logic [47:0] SAT_POS = 48'h7FFF_FFFF_FFFF;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [19:0] min_temp_reg;
    logic [31:0] inv_temp_reg;
    logic [7:0]  temp_pts_reg;
    logic [39:0] min_press_reg;
    logic [31:0] inv_press_reg;
    logic [7:0]  press_pts_reg;
    logic        interp_reg;
    logic        cfg_write;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_temp_reg  <= '0;
            inv_temp_reg  <= 32'd65536;
            temp_pts_reg  <= 8'd2;
            min_press_reg <= '0;
            inv_press_reg <= 32'd65536;
            press_pts_reg <= 8'd2;
            interp_reg    <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (paddr[5:3])
                REG_MIN_TEMP:  min_temp_reg  <= pwdata[19:0];
                REG_INV_TEMP:  inv_temp_reg  <= pwdata[31:0];
                REG_TEMP_PTS:  temp_pts_reg  <= pwdata[7:0];
                REG_MIN_PRESS: min_press_reg <= pwdata[39:0];
                REG_INV_PRESS: inv_press_reg <= pwdata[31:0];
                REG_PRESS_PTS: press_pts_reg <= pwdata[7:0];
                REG_INTERP:    interp_reg    <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_MIN_TEMP:  prdata = {44'd0, min_temp_reg};
            REG_INV_TEMP:  prdata = {32'd0, inv_temp_reg};
            REG_TEMP_PTS:  prdata = {56'd0, temp_pts_reg};
            REG_MIN_PRESS: prdata = {24'd0, min_press_reg};
            REG_INV_PRESS: prdata = {32'd0, inv_press_reg};
            REG_PRESS_PTS: prdata = {56'd0, press_pts_reg};
            REG_INTERP:    prdata = {63'd0, interp_reg};
            default:       prdata = '0;
        endcase
    end

    // Effective point counts and the clamp and range limits they give.
    logic [CNT_W-1:0]        tp_in, pp_in, tp_eff, pp_eff;
    logic signed [POS_W-1:0] lim_t, lim_p, top_t, top_p;

    always_comb
    begin
        tp_in = CNT_W'(temp_pts_reg);
        pp_in = CNT_W'(press_pts_reg);
        if (tp_in < CNT_W'(2))
            tp_eff = CNT_W'(2);
        else if (tp_in > CNT_W'(MAX_TEMP_POINTS))
            tp_eff = CNT_W'(MAX_TEMP_POINTS);
        else
            tp_eff = tp_in;
        if (pp_in < CNT_W'(2))
            pp_eff = CNT_W'(2);
        else if (pp_in > CNT_W'(MAX_PRESS_POINTS))
            pp_eff = CNT_W'(MAX_PRESS_POINTS);
        else
            pp_eff = pp_in;
        lim_t = $signed(POS_W'(tp_eff - CNT_W'(2)) << 16);
        lim_p = $signed(POS_W'(pp_eff - CNT_W'(2)) << 16);
        top_t = $signed(POS_W'(tp_eff - CNT_W'(1)) << 16);
        top_p = $signed(POS_W'(pp_eff - CNT_W'(1)) << 16);
    end

    // ------------------------------------------------------------------
    // Issue control: no item is taken while busy is high.
    // ------------------------------------------------------------------
    logic busy_reg;
    logic accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= accept;
    end

    // ------------------------------------------------------------------
    // Stage 1: request capture with the offsets from the first grid point.
    // ------------------------------------------------------------------
    logic        s1_valid;
    req_t        s1_req;
    logic        s1_tneg, s1_pneg;
    logic [19:0] s1_toff;
    logic [39:0] s1_poff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid <= 1'b0;
        else
            s1_valid <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req.lookup    <= req_type;
            s1_req.table_sel <= table_select;
            s1_req.row       <= row_index;
            s1_req.col       <= col_index;
            s1_req.entry     <= entry_data;
            s1_req.quantity  <= quantity;
            s1_tneg          <= temperature < min_temp_reg;
            s1_pneg          <= pressure < min_press_reg;
            s1_toff          <= (temperature < min_temp_reg) ? min_temp_reg - temperature
                                                             : temperature - min_temp_reg;
            s1_poff          <= (pressure < min_press_reg) ? min_press_reg - pressure
                                                           : pressure - min_press_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: offset times reciprocal step; pressure is split at bit 32.
    // ------------------------------------------------------------------
    logic        s2_valid;
    req_t        s2_req;
    logic        s2_tneg, s2_pneg;
    logic [51:0] s2_tprod;
    logic [63:0] s2_plo;
    logic [39:0] s2_phi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid <= 1'b0;
        else
            s2_valid <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        s2_req   <= s1_req;
        s2_tneg  <= s1_tneg;
        s2_pneg  <= s1_pneg;
        s2_tprod <= 52'(s1_toff) * 52'(inv_temp_reg);
        s2_plo   <= 64'(s1_poff[31:0]) * 64'(inv_press_reg);
        s2_phi   <= 40'(s1_poff[39:32]) * 40'(inv_press_reg);
    end

    // ------------------------------------------------------------------
    // Stage 3: signed Q.16 grid positions.
    // ------------------------------------------------------------------
    logic                    s3_valid;
    req_t                    s3_req;
    logic                    s3_tneg, s3_pneg;
    logic signed [POS_W-1:0] s3_pos_t, s3_pos_p;
    logic signed [POS_W-1:0] tmag, pmag;

    assign tmag = $signed(POS_W'(s2_tprod[51:16]));
    assign pmag = $signed(POS_W'({s2_phi, 16'd0}) + POS_W'(s2_plo[63:16]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid <= 1'b0;
        else
            s3_valid <= s2_valid;
    end

    always_ff @(posedge clk)
    begin
        s3_req   <= s2_req;
        s3_tneg  <= s2_tneg;
        s3_pneg  <= s2_pneg;
        s3_pos_t <= s2_tneg ? -tmag : tmag;
        s3_pos_p <= s2_pneg ? -pmag : pmag;
    end

    // ------------------------------------------------------------------
    // Stage 4: clamp the base point and the next-step point, pick the table.
    // ------------------------------------------------------------------
    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [POS_W-1:0] pos,
                                                   input logic signed [POS_W-1:0] lim);
        logic [POS_W-1:0] c;
        if (pos[POS_W-1])
            c = '0;
        else if (pos > lim)
            c = lim;
        else
            c = pos;
        return c;
    endfunction

    logic                    s4_valid;
    req_t                    s4_req;
    item_t                   s4_item;
    logic [2:0]              s4_tbl;
    logic                    s4_interp;
    logic [POS_W-1:0]        s4_at, s4_ap, s4_bt, s4_bp;
    logic signed [POS_W-1:0] bpos_t, bpos_p;
    logic [2:0]              tbl_sel;
    logic                    interp_sel;
    item_t                   item_c;

    always_comb
    begin
        bpos_t = s3_pos_t;
        bpos_p = s3_pos_p;
        if (s3_req.quantity == Q_DHDT)
            bpos_t = s3_pos_t + POS_W'(65536);
        else if (s3_req.quantity == Q_DHDP || s3_req.quantity == Q_DRHODP)
            bpos_p = s3_pos_p + POS_W'(65536);

        if (s3_req.quantity <= Q_ENTHALPY)
            tbl_sel = s3_req.quantity[2:0];
        else if (s3_req.quantity == Q_DRHODP)
            tbl_sel = TBL_DENSITY;
        else
            tbl_sel = TBL_ENTHALPY;

        // Vp and Vs are always read at the floor index.
        interp_sel = (tbl_sel == TBL_VP || tbl_sel == TBL_VS) ? 1'b0 : interp_reg;

        item_c.lookup      = s3_req.lookup;
        item_c.quantity    = s3_req.quantity;
        item_c.temp_below  = s3_tneg;
        item_c.temp_above  = s3_pos_t > top_t;
        item_c.press_below = s3_pneg;
        item_c.press_above = s3_pos_p > top_p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid <= 1'b0;
        else
            s4_valid <= s3_valid;
    end

    always_ff @(posedge clk)
    begin
        s4_req    <= s3_req;
        s4_item   <= item_c;
        s4_tbl    <= tbl_sel;
        s4_interp <= interp_sel;
        s4_at     <= clamp_pos(s3_pos_t, lim_t);
        s4_ap     <= clamp_pos(s3_pos_p, lim_p);
        s4_bt     <= clamp_pos(bpos_t, lim_t);
        s4_bp     <= clamp_pos(bpos_p, lim_p);
    end

    // Stage 5 holds the next-step point for the second memory read.
    logic             s5_valid;
    item_t            s5_item;
    logic [2:0]       s5_tbl;
    logic             s5_interp;
    logic [POS_W-1:0] s5_bt, s5_bp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid <= 1'b0;
        else
            s5_valid <= s4_valid;
    end

    always_ff @(posedge clk)
    begin
        s5_item   <= s4_item;
        s5_tbl    <= s4_tbl;
        s5_interp <= s4_interp;
        s5_bt     <= s4_bt;
        s5_bp     <= s4_bp;
    end

    // ------------------------------------------------------------------
    // Banked table memories. Bank {row parity, column parity} holds every
    // entry of that parity, so the four corners of a cell are read at once.
    // The base point is read from the s4 registers and the next-step point from
    // the s5 registers. Writes are issued from the s4 registers, which keeps
    // every read and write in item order without forwarding.
    // ------------------------------------------------------------------
    function automatic logic [BANK_AW-1:0] bank_addr(input logic [2:0]       t,
                                                     input logic [ROW_W-1:0] rh,
                                                     input logic [COL_W-1:0] ch);
        logic [BANK_AW-1:0] a;
        a = BANK_AW'(t) * BANK_AW'(TSTRIDE) + BANK_AW'(rh) * BANK_AW'(HALF_P)
            + BANK_AW'(ch);
        return a;
    endfunction

    logic                    rd_b;
    logic                    rd_interp;
    logic [2:0]              rd_tbl;
    logic [POS_W-1:0]        rd_pt, rd_pp;
    logic [ROW_W-1:0]        rd_r;
    logic [COL_W-1:0]        rd_c;
    item_t                   rd_item;
    logic                    wr_ok;
    logic [1:0]              wr_bank;
    logic [BANK_AW-1:0]      wr_addr;
    logic [3:0]              ram_we;
    logic [BANK_AW-1:0]      ram_raddr [4];
    logic [31:0]             ram_rdata [4];

    always_comb
    begin
        rd_b      = s5_valid;
        rd_interp = s5_valid ? s5_interp : s4_interp;
        rd_tbl    = s5_valid ? s5_tbl : s4_tbl;
        rd_pt     = s5_valid ? s5_bt : s4_at;
        rd_pp     = s5_valid ? s5_bp : s4_ap;
        rd_item   = s5_valid ? s5_item : s4_item;
        rd_r      = rd_pt[ROW_W+15:16];
        rd_c      = rd_pp[COL_W+15:16];

        wr_ok   = (32'(s4_req.table_sel) < 32'(BPT_NUM_TABLES))
                  && (32'(s4_req.row) < 32'(MAX_TEMP_POINTS))
                  && (32'(s4_req.col) < 32'(MAX_PRESS_POINTS));
        wr_bank = {s4_req.row[0], s4_req.col[0]};
        wr_addr = bank_addr(s4_req.table_sel, ROW_W'(s4_req.row >> 1),
                            COL_W'(s4_req.col >> 1));
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [ROW_W-1:0] row_b;
        logic [COL_W-1:0] col_b;

        always_comb
        begin
            row_b = (rd_r[0] == 1'(b >> 1)) ? rd_r : rd_r + ROW_W'(1);
            col_b = (rd_c[0] == 1'(b & 1)) ? rd_c : rd_c + COL_W'(1);
            ram_raddr[b] = bank_addr(rd_tbl, row_b >> 1, col_b >> 1);
            ram_we[b]    = s4_valid && (s4_req.lookup == REQ_WRITE) && wr_ok
                           && (wr_bank == 2'(b));
        end

        bpt_ram #(
            .WIDTH (32),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[b]),
            .waddr (wr_addr),
            .wdata (s4_req.entry),
            .raddr (ram_raddr[b]),
            .rdata (ram_rdata[b])
        );
    end

    // ------------------------------------------------------------------
    // Shared interpolation unit, one point per cycle.
    // U0: corners arrive; weight the temperature differences.
    // ------------------------------------------------------------------
    logic        u0_valid, u0_b, u0_interp, u0_rpar, u0_cpar;
    logic [15:0] u0_xi, u0_eta;
    item_t       u0_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            u0_valid <= 1'b0;
        else
            u0_valid <= s4_valid || s5_valid;
    end

    always_ff @(posedge clk)
    begin
        u0_b      <= rd_b;
        u0_interp <= rd_interp;
        u0_rpar   <= rd_r[0];
        u0_cpar   <= rd_c[0];
        u0_xi     <= rd_pt[15:0];
        u0_eta    <= rd_pp[15:0];
        u0_item   <= rd_item;
    end

    logic signed [31:0] e00, e10, e01, e11;
    logic signed [32:0] d0, d1;

    always_comb
    begin
        e00 = $signed(ram_rdata[{u0_rpar, u0_cpar}]);
        e10 = $signed(ram_rdata[{~u0_rpar, u0_cpar}]);
        e01 = $signed(ram_rdata[{u0_rpar, ~u0_cpar}]);
        e11 = $signed(ram_rdata[{~u0_rpar, ~u0_cpar}]);
        d0  = {e10[31], e10} - {e00[31], e00};
        d1  = {e11[31], e11} - {e01[31], e01};
    end

    logic               u1_valid, u1_b, u1_interp;
    logic [15:0]        u1_eta;
    item_t              u1_item;
    logic signed [31:0] u1_e00, u1_e01;
    logic signed [49:0] u1_p0, u1_p1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            u1_valid <= 1'b0;
        else
            u1_valid <= u0_valid;
    end

    always_ff @(posedge clk)
    begin
        u1_b      <= u0_b;
        u1_interp <= u0_interp;
        u1_eta    <= u0_eta;
        u1_item   <= u0_item;
        u1_e00    <= e00;
        u1_e01    <= e01;
        u1_p0     <= d0 * $signed({1'b0, u0_xi});
        u1_p1     <= d1 * $signed({1'b0, u0_xi});
    end

    // U1: both temperature-direction sums and their pressure difference.
    logic signed [49:0] s0_c, s1_c;
    logic signed [50:0] ds_c;

    always_comb
    begin
        s0_c = ($signed({{18{u1_e00[31]}}, u1_e00}) <<< 16) + u1_p0;
        s1_c = ($signed({{18{u1_e01[31]}}, u1_e01}) <<< 16) + u1_p1;
        ds_c = {s1_c[49], s1_c} - {s0_c[49], s0_c};
    end

    logic               u2_valid, u2_b, u2_interp;
    logic [15:0]        u2_eta;
    item_t              u2_item;
    logic signed [31:0] u2_e00;
    logic signed [49:0] u2_s0;
    logic signed [50:0] u2_ds;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            u2_valid <= 1'b0;
        else
            u2_valid <= u1_valid;
    end

    always_ff @(posedge clk)
    begin
        u2_b      <= u1_b;
        u2_interp <= u1_interp;
        u2_eta    <= u1_eta;
        u2_item   <= u1_item;
        u2_e00    <= u1_e00;
        u2_s0     <= s0_c;
        u2_ds     <= ds_c;
    end

    // U2: pressure weight.
    logic               u3_valid, u3_b, u3_interp;
    item_t              u3_item;
    logic signed [31:0] u3_e00;
    logic signed [49:0] u3_s0;
    logic signed [67:0] u3_p2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            u3_valid <= 1'b0;
        else
            u3_valid <= u2_valid;
    end

    always_ff @(posedge clk)
    begin
        u3_b      <= u2_b;
        u3_interp <= u2_interp;
        u3_item   <= u2_item;
        u3_e00    <= u2_e00;
        u3_s0     <= u2_s0;
        u3_p2     <= u2_ds * $signed({1'b0, u2_eta});
    end

    // U3: final sum, rounded half up to the table scale, or the floor entry.
    logic signed [67:0]      sum_c;
    logic signed [VAL_W-1:0] val_c;

    always_comb
    begin
        sum_c = $signed({{2{u3_s0[49]}}, u3_s0, 16'd0}) + u3_p2
                + $signed(68'd2147483648);
        if (u3_interp)
            val_c = sum_c[VAL_W+31:32];
        else
            val_c = {{(VAL_W-32){u3_e00[31]}}, u3_e00};
    end

    logic                    v_valid, v_b;
    item_t                   v_item;
    logic signed [VAL_W-1:0] v_val;
    logic signed [VAL_W-1:0] a_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_valid <= 1'b0;
        else
            v_valid <= u3_valid;
    end

    always_ff @(posedge clk)
    begin
        v_b    <= u3_b;
        v_item <= u3_item;
        v_val  <= val_c;
        // The base point always comes out in the cycle before the next-step one.
        if (v_valid && !v_b)
            a_val_reg <= v_val;
    end

    // ------------------------------------------------------------------
    // Result stages: pass the base value, or difference, scale by the reciprocal step and saturate.
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] diff_c;

    assign diff_c = v_val - a_val_reg;

    logic                    d0_valid, d0_neg;
    item_t                   d0_item;
    logic signed [VAL_W-1:0] d0_a;
    logic [VAL_W-1:0]        d0_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d0_valid <= 1'b0;
        else
            d0_valid <= v_valid && v_b;
    end

    always_ff @(posedge clk)
    begin
        d0_item <= v_item;
        d0_a    <= a_val_reg;
        d0_neg  <= diff_c[VAL_W-1];
        d0_mag  <= diff_c[VAL_W-1] ? VAL_W'(-diff_c) : VAL_W'(diff_c);
    end

    logic                    d1_valid, d1_neg;
    item_t                   d1_item;
    logic signed [VAL_W-1:0] d1_a;
    logic [63:0]             d1_plo;
    logic [33:0]             d1_phi;
    logic [31:0]             inv_sel;

    assign inv_sel = (d0_item.quantity == Q_DHDT) ? inv_temp_reg : inv_press_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d1_valid <= 1'b0;
        else
            d1_valid <= d0_valid;
    end

    always_ff @(posedge clk)
    begin
        d1_item <= d0_item;
        d1_a    <= d0_a;
        d1_neg  <= d0_neg;
        d1_plo  <= 64'(d0_mag[31:0]) * 64'(inv_sel);
        d1_phi  <= 34'(d0_mag[VAL_W-1:32]) * 34'(inv_sel);
    end

    logic [50:0]        scaled;
    logic [47:0]        mag48;
    logic signed [47:0] res_c;

    always_comb
    begin
        scaled = 51'({d1_phi, 16'd0}) + 51'(d1_plo[63:16]);
        if (!d1_neg && scaled > 51'(SAT_POS))
            mag48 = SAT_POS;
        else if (d1_neg && scaled > 51'(SAT_POS) + 51'd1)
            mag48 = SAT_POS + 48'd1;
        else
            mag48 = scaled[47:0];

        if (d1_item.lookup != REQ_LOOKUP)
            res_c = '0;
        else if (d1_item.quantity <= Q_ENTHALPY)
            res_c = {{(48-VAL_W){d1_a[VAL_W-1]}}, d1_a};
        else if (d1_item.quantity == Q_DHDT || d1_item.quantity == Q_DHDP
                 || d1_item.quantity == Q_DRHODP)
            res_c = d1_neg ? $signed(-mag48) : $signed(mag48);
        else
            res_c = '0;
    end

    logic               done_reg;
    logic signed [47:0] result_reg;
    logic [3:0]         flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_c;
        if (d1_item.lookup == REQ_LOOKUP)
            flags_reg <= {d1_item.temp_below, d1_item.temp_above,
                          d1_item.press_below, d1_item.press_above};
        else
            flags_reg <= '0;
    end

    assign done         = done_reg;
    assign result_value = result_reg;
    assign temp_below   = flags_reg[3];
    assign temp_above   = flags_reg[2];
    assign press_below  = flags_reg[1];
    assign press_above  = flags_reg[0];

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted transfer");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    a_second_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid |=> s5_valid && !s4_valid)
        else $error("next-step read slot did not follow the base read");

    a_results_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in adjacent cycles");

    a_write_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we != 4'd0) |-> $onehot(ram_we) && !s5_valid)
        else $error("table write outside its slot");
`endif

endmodule

// ===== hw/rtl/bpt_ram.sv =====
// ----------------------------------------------------------------------------
// bpt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/bpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpt_checker
// Watches the request, result and register channels of the property table
// block, predicts each result and compares it with what the block returns.
// ----------------------------------------------------------------------------
module bpt_checker
    import bpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               req_type,
    input  logic [2:0]         table_select,
    input  logic [6:0]         row_index,
    input  logic [6:0]         col_index,
    input  logic signed [31:0] entry_data,
    input  logic [19:0]        temperature,
    input  logic [39:0]        pressure,
    input  logic [3:0]         quantity,
    input  logic               done,
    input  logic signed [47:0] result_value,
    input  logic               temp_below,
    input  logic               temp_above,
    input  logic               press_below,
    input  logic               press_above,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending
);

    localparam logic [63:0] SAT_POS = 64'h0000_7FFF_FFFF_FFFF;

    typedef struct {
        logic signed [47:0] value;
        logic               t_below;
        logic               t_above;
        logic               p_below;
        logic               p_above;
    } outcome_t;

    // Mirror of the configuration registers.
    logic [19:0] min_temp_r;
    logic [31:0] inv_temp_r;
    logic [7:0]  temp_pts_r;
    logic [39:0] min_press_r;
    logic [31:0] inv_press_r;
    logic [7:0]  press_pts_r;
    logic        interp_r;

    int          prop_table [BPT_NUM_TABLES][BPT_MAX_TEMP_POINTS][BPT_MAX_PRESS_POINTS];
    outcome_t    expected_q [$];

    function automatic logic [63:0] mul_shift16(logic [63:0] off, logic [31:0] inv);
        logic [95:0] prod;
        prod = {32'b0, off} * {64'b0, inv};
        return prod[79:16];
    endfunction

    function automatic longint grid_position(logic [63:0] v, logic [63:0] minv,
                                             logic [31:0] inv);
        if (v >= minv)
            return longint'(mul_shift16(v - minv, inv));
        return -longint'(mul_shift16(minv - v, inv));
    endfunction

    function automatic int eff_count(logic [7:0] pts, int maxp);
        if (pts < 2)
            return 2;
        if (pts > maxp)
            return maxp;
        return int'(pts);
    endfunction

    function automatic longint clamp_position(longint pos, int pts);
        longint lim;
        lim = longint'(pts - 2) <<< 16;
        if (pos < 0)
            return 0;
        if (pos > lim)
            return lim;
        return pos;
    endfunction

    function automatic longint table_value(int t, longint pos_t, longint pos_p, bit interp);
        longint              ct;
        longint              cp;
        int                  r;
        int                  c;
        longint              xi;
        longint              eta;
        logic signed [79:0]  s0;
        logic signed [79:0]  s1;
        logic signed [79:0]  sum;
        ct  = clamp_position(pos_t, eff_count(temp_pts_r, BPT_MAX_TEMP_POINTS));
        cp  = clamp_position(pos_p, eff_count(press_pts_r, BPT_MAX_PRESS_POINTS));
        r   = int'(ct >>> 16);
        c   = int'(cp >>> 16);
        xi  = ct & 64'hFFFF;
        eta = cp & 64'hFFFF;
        if (!interp)
            return longint'(prop_table[t][r][c]);
        // Along temperature first, then along pressure, round half up.
        s0  = longint'(prop_table[t][r][c]) * (65536 - xi)
            + longint'(prop_table[t][r + 1][c]) * xi;
        s1  = longint'(prop_table[t][r][c + 1]) * (65536 - xi)
            + longint'(prop_table[t][r + 1][c + 1]) * xi;
        sum = s0 * (65536 - eta) + s1 * eta;
        return longint'((sum + 80'sd2147483648) >>> 32);
    endfunction

    function automatic longint slope(longint diff, logic [31:0] inv);
        bit          neg;
        logic [63:0] mag;
        logic [63:0] r;
        neg = diff < 0;
        mag = neg ? 64'(-diff) : 64'(diff);
        r   = mul_shift16(mag, inv);
        if (!neg && r > SAT_POS)
            r = SAT_POS;
        if (neg && r > SAT_POS + 1)
            r = SAT_POS + 1;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic outcome_t predict_lookup(logic [19:0] temp_in, logic [39:0] press_in,
                                                logic [3:0] q);
        outcome_t o;
        longint   pt;
        longint   pp;
        longint   v;
        int       tp;
        int       np;
        tp = eff_count(temp_pts_r, BPT_MAX_TEMP_POINTS);
        np = eff_count(press_pts_r, BPT_MAX_PRESS_POINTS);
        pt = grid_position(64'(temp_in), 64'(min_temp_r), inv_temp_r);
        pp = grid_position(64'(press_in), 64'(min_press_r), inv_press_r);
        v  = 0;
        if (q <= Q_ENTHALPY) begin
            // Velocities are always taken from the floor entry.
            v = table_value(int'(q), pt, pp,
                            (q == 4'(TBL_VP) || q == 4'(TBL_VS)) ? 1'b0 : interp_r);
        end else if (q == Q_DHDT) begin
            v = slope(table_value(int'(TBL_ENTHALPY), pt + 65536, pp, interp_r)
                      - table_value(int'(TBL_ENTHALPY), pt, pp, interp_r), inv_temp_r);
        end else if (q == Q_DHDP) begin
            v = slope(table_value(int'(TBL_ENTHALPY), pt, pp + 65536, interp_r)
                      - table_value(int'(TBL_ENTHALPY), pt, pp, interp_r), inv_press_r);
        end else if (q == Q_DRHODP) begin
            v = slope(table_value(int'(TBL_DENSITY), pt, pp + 65536, interp_r)
                      - table_value(int'(TBL_DENSITY), pt, pp, interp_r), inv_press_r);
        end
        o.value   = v[47:0];
        o.t_below = temp_in < min_temp_r;
        o.t_above = pt > (longint'(tp - 1) <<< 16);
        o.p_below = press_in < min_press_r;
        o.p_above = pp > (longint'(np - 1) <<< 16);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        outcome_t exp_o;
        outcome_t got_o;
        if (!rst_n) begin
            min_temp_r  <= '0;
            inv_temp_r  <= 32'd65536;
            temp_pts_r  <= 8'd2;
            min_press_r <= '0;
            inv_press_r <= 32'd65536;
            press_pts_r <= 8'd2;
            interp_r    <= 1'b1;
            fail_count  = 0;
            pending     = 0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_MIN_TEMP:  min_temp_r  <= pwdata[19:0];
                    REG_INV_TEMP:  inv_temp_r  <= pwdata[31:0];
                    REG_TEMP_PTS:  temp_pts_r  <= pwdata[7:0];
                    REG_MIN_PRESS: min_press_r <= pwdata[39:0];
                    REG_INV_PRESS: inv_press_r <= pwdata[31:0];
                    REG_PRESS_PTS: press_pts_r <= pwdata[7:0];
                    REG_INTERP:    interp_r    <= pwdata[0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (req_type == REQ_WRITE) begin
                    if (table_select < BPT_NUM_TABLES)
                        prop_table[table_select][row_index][col_index] = entry_data;
                    exp_o = '{value: '0, t_below: 0, t_above: 0, p_below: 0, p_above: 0};
                end else begin
                    exp_o = predict_lookup(temperature, pressure, quantity);
                end
                expected_q.push_back(exp_o);
            end
            if (done) begin
                got_o = '{value: result_value, t_below: temp_below, t_above: temp_above,
                          p_below: press_below, p_above: press_above};
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected: value %0d flags %b%b%b%b",
                             $time, result_value, temp_below, temp_above,
                             press_below, press_above);
                    fail_count++;
                end else begin
                    exp_o = expected_q.pop_front();
                    if (got_o != exp_o) begin
                        $display("%0t: mismatch: expected value %0d flags %b%b%b%b, got %0d %b%b%b%b",
                                 $time, exp_o.value, exp_o.t_below, exp_o.t_above,
                                 exp_o.p_below, exp_o.p_above, got_o.value, got_o.t_below,
                                 got_o.t_above, got_o.p_below, got_o.p_above);
                        fail_count++;
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== tb/tb_bilinear_property_table_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_property_table_lookup
// Drives table writes and lookups into the property table block through a
// series of register settings and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_bilinear_property_table_lookup;
    import bpt_pkg::*;

    // Idle time after the last expected result, before the registers change.
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 600000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               req_type = REQ_WRITE;
    logic [2:0]         table_select = '0;
    logic [6:0]         row_index = '0;
    logic [6:0]         col_index = '0;
    logic signed [31:0] entry_data = '0;
    logic [19:0]        temperature = '0;
    logic [39:0]        pressure = '0;
    logic [3:0]         quantity = '0;
    logic               done;
    logic signed [47:0] result_value;
    logic               temp_below;
    logic               temp_above;
    logic               press_below;
    logic               press_above;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [5:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;

    // Which entries hold a value; lookups must never touch an unwritten one.
    bit                 written [BPT_NUM_TABLES][BPT_MAX_TEMP_POINTS][BPT_MAX_PRESS_POINTS];

    // Mirror of the current setting, used to aim lookups at the grid.
    logic [19:0]        cur_min_temp = '0;
    logic [31:0]        cur_inv_temp = 32'd65536;
    logic [39:0]        cur_min_press = '0;
    logic [31:0]        cur_inv_press = 32'd65536;
    int                 cur_tp = 2;
    int                 cur_pp = 2;

    // When set, the sender never idles between transfers.
    bit                 calm = 1'b0;

    bilinear_property_table_lookup u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .table_select (table_select),
        .row_index    (row_index),
        .col_index    (col_index),
        .entry_data   (entry_data),
        .temperature  (temperature),
        .pressure     (pressure),
        .quantity     (quantity),
        .done         (done),
        .result_value (result_value),
        .temp_below   (temp_below),
        .temp_above   (temp_above),
        .press_below  (press_below),
        .press_above  (press_above),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    bpt_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .table_select (table_select),
        .row_index    (row_index),
        .col_index    (col_index),
        .entry_data   (entry_data),
        .temperature  (temperature),
        .pressure     (pressure),
        .quantity     (quantity),
        .done         (done),
        .result_value (result_value),
        .temp_below   (temp_below),
        .temp_above   (temp_above),
        .press_below  (press_below),
        .press_above  (press_above),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bilinear_property_table_lookup test failed");
            $finish;
        end
    end

    function automatic int eff_count(int pts);
        if (pts < 2)
            return 2;
        if (pts > 128)
            return 128;
        return pts;
    endfunction

    // A random table entry, with the two extremes turning up often so that
    // interpolation sums and derivative saturation see their limits.
    function automatic logic [31:0] entry_pick();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // A coordinate of the given width, mostly aimed from just below the
    // first grid point to just beyond the last one, now and then anywhere.
    function automatic logic [63:0] near_coord(logic [63:0] minv, logic [31:0] inv,
                                               int pts, int w);
        logic [63:0] mask;
        logic [63:0] off;
        longint      g;
        longint      v;
        mask = (64'd1 << w) - 1;
        if (inv == 0 || $urandom_range(0, 4) == 0)
            return {$urandom, $urandom} & mask;
        // g is the target grid position in units of 1/256 step.
        g   = longint'($urandom_range(0, (pts + 3) * 256)) - 512;
        off = (64'(g < 0 ? -g : g) << 24) / inv;
        v   = g < 0 ? longint'(minv) - longint'(off) : longint'(minv) + longint'(off);
        if (v < 0)
            return 64'd0;
        if (v > longint'(mask))
            return mask;
        return 64'(v);
    endfunction

    // One command transfer. Every field gets a value, also those the request
    // type ignores, so that each input bit toggles.
    task automatic transfer(logic rt, logic [2:0] ts, logic [6:0] r, logic [6:0] c,
                            logic [31:0] d, logic [19:0] t, logic [39:0] p, logic [3:0] q);
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= rt;
        table_select <= ts;
        row_index    <= r;
        col_index    <= c;
        entry_data   <= d;
        temperature  <= t;
        pressure     <= p;
        quantity     <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (rt == REQ_WRITE && ts < BPT_NUM_TABLES)
            written[ts][r][c] = 1'b1;
    endtask

    task automatic write_entry(logic [2:0] ts, logic [6:0] r, logic [6:0] c, logic [31:0] d);
        transfer(REQ_WRITE, ts, r, c, d, 20'($urandom), {$urandom, $urandom},
                 4'($urandom));
    endtask

    task automatic lookup_at(logic [19:0] t, logic [39:0] p, logic [3:0] q);
        transfer(REQ_LOOKUP, 3'($urandom), 7'($urandom), 7'($urandom), $urandom, t, p, q);
    endtask

    // Stop sending and let every expected result come back, then leave the
    // pipeline time to empty before the registers change.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Load every entry of the active grid that has no value yet, without
    // idle gaps, so that any lookup in this setting reads written entries.
    task automatic fill_grid(int tp, int pp);
        bit save;
        save = calm;
        calm = 1'b1;
        for (int t = 0; t < BPT_NUM_TABLES; t++)
            for (int r = 0; r < tp; r++)
                for (int c = 0; c < pp; c++)
                    if (!written[t][r][c])
                        write_entry(3'(t), 7'(r), 7'(c), entry_pick());
        calm = save;
    endtask

    // One setting of all seven registers, followed by random traffic. Most
    // items are lookups aimed at the grid; the rest are writes anywhere,
    // ignored writes to the two unused table codes among them.
    task automatic run_phase(logic [19:0] mt, logic [31:0] it, int tp,
                             logic [39:0] mp, logic [31:0] ip, int pp,
                             logic interp, int n_items);
        settle();
        reg_write(REG_MIN_TEMP, 64'(mt));
        reg_write(REG_INV_TEMP, 64'(it));
        reg_write(REG_TEMP_PTS, 64'(tp));
        reg_write(REG_MIN_PRESS, 64'(mp));
        reg_write(REG_INV_PRESS, 64'(ip));
        reg_write(REG_PRESS_PTS, 64'(pp));
        reg_write(REG_INTERP, 64'(interp));
        cur_min_temp  = mt;
        cur_inv_temp  = it;
        cur_min_press = mp;
        cur_inv_press = ip;
        cur_tp        = eff_count(tp);
        cur_pp        = eff_count(pp);
        fill_grid(cur_tp, cur_pp);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 9) < 3)
                write_entry(3'($urandom), 7'($urandom), 7'($urandom), entry_pick());
            else
                lookup_at(20'(near_coord(64'(cur_min_temp), cur_inv_temp, cur_tp, 20)),
                          40'(near_coord(64'(cur_min_press), cur_inv_press, cur_pp, 40)),
                          4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset setting: a 2 x 2 grid with unit
        // reciprocal steps. Entries alternate between the two extremes.
        for (int t = 0; t < BPT_NUM_TABLES; t++)
            for (int r = 0; r < 2; r++)
                for (int c = 0; c < 2; c++)
                    write_entry(3'(t), 7'(r), 7'(c),
                                ((t + r + c) % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
        // Writes to the two table codes that do not exist are ignored.
        write_entry(3'd6, 7'd0, 7'd0, 32'h1234_5678);
        write_entry(3'd7, 7'd127, 7'd127, 32'hFFFF_FFFF);
        // Every quantity, the unknown codes included, at a point inside the
        // grid, then the field extremes on both axes.
        for (int q = 0; q < 16; q++)
            lookup_at(20'd32768, 40'd40000, 4'(q));
        lookup_at(20'd0, 40'd0, Q_DHDT);
        lookup_at(20'hFFFFF, 40'hFF_FFFF_FFFF, Q_DHDP);
        lookup_at(20'hFFFFF, 40'd0, Q_DRHODP);
        lookup_at(20'd0, 40'hFF_FFFF_FFFF, Q_ENTHALPY);

        // Random settings, typical sizes first.
        run_phase(20'($urandom), $urandom_range(256, 1 << 20), 5,
                  {8'($urandom), $urandom}, $urandom_range(1, 1 << 12), 7, 1'b1, 135);
        run_phase(20'($urandom), $urandom_range(256, 1 << 20), 3,
                  {8'($urandom), $urandom}, $urandom_range(1, 1 << 12), 4, 1'b0, 135);
        // Extremes: the largest grid on one axis with the largest step value,
        // counts beyond the range and below it, zero steps, top minimums.
        run_phase(20'd0, 32'hFFFF_FFFF, 128, 40'd0, $urandom_range(1, 1 << 12), 2,
                  1'b1, 135);
        run_phase(20'hFFFFF, 32'd0, 255, {8'($urandom), $urandom}, 32'd0, 1, 1'b0, 135);
        run_phase(20'($urandom), $urandom_range(1 << 16, 1 << 24), 2,
                  40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 128, 1'b1, 135);
        run_phase(20'($urandom), $urandom_range(256, 1 << 20), 0,
                  {8'($urandom), $urandom}, $urandom_range(1, 1 << 8), 200, 1'b1, 135);
        // The last stretch runs with no sender gaps at all.
        calm = 1'b1;
        run_phase(20'($urandom), $urandom_range(256, 1 << 20), 6,
                  {8'($urandom), $urandom}, $urandom_range(1, 1 << 12), 6, 1'b1, 135);

        settle();
        if (fail_count == 0)
            $display("bilinear_property_table_lookup test passed");
        else
            $display("bilinear_property_table_lookup test failed");
        $finish;
    end

endmodule
